// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl of the led sequencer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/slbs_pkg.sv =====
// ---------------------------------------------------------------------------
// slbs_pkg
// shared widths, codes, blink tables and the result record
// ---------------------------------------------------------------------------
package slbs_pkg;

    localparam int PAT_W  = 4;
    localparam int STEP_W = 3;
    localparam int TIME_W = 32;
    localparam int DUR_W  = 12;

    // pattern codes
    localparam logic [PAT_W-1:0] PAT_BOOT  = 4'd0;
    localparam logic [PAT_W-1:0] PAT_PROV  = 4'd1;
    localparam logic [PAT_W-1:0] PAT_CONN  = 4'd2;
    localparam logic [PAT_W-1:0] PAT_LOCAL = 4'd3;
    localparam logic [PAT_W-1:0] PAT_CLOUD = 4'd4;
    localparam logic [PAT_W-1:0] PAT_FAULT = 4'd5;
    localparam logic [PAT_W-1:0] PAT_OTA   = 4'd6;
    localparam logic [PAT_W-1:0] PAT_OFF   = 4'd7;
    localparam logic [PAT_W-1:0] PAT_SOLID = 4'd8;
    localparam logic [PAT_W-1:0] PAT_MAX   = PAT_SOLID;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // configuration register indexes
    localparam logic REG_LED_PRESENT = 1'b0;
    localparam logic REG_ACTIVE_LOW  = 1'b1;

    typedef struct packed {
        logic              pin_level;
        logic              led_lit;
        logic              pin_written;
        logic [PAT_W-1:0]  current_pattern;
        logic [STEP_W-1:0] step_index;
    } slbs_result_t;

    // number of steps in a pattern's cycle, zero for static patterns
    function automatic logic [STEP_W-1:0] step_count(input logic [PAT_W-1:0] pat);
        logic [STEP_W-1:0] cnt;
        unique case (pat)
            PAT_PROV, PAT_CONN, PAT_LOCAL, PAT_OTA: cnt = 3'd2;
            PAT_CLOUD:                              cnt = 3'd4;
            PAT_FAULT:                              cnt = 3'd6;
            default:                                cnt = 3'd0;
        endcase
        return cnt;
    endfunction

    // duration of one step in ms
    function automatic logic [DUR_W-1:0] step_dur(input logic [PAT_W-1:0] pat,
                                                  input logic [STEP_W-1:0] step);
        logic [DUR_W-1:0] dur;
        unique case (pat)
            PAT_PROV:  dur = 12'd120;
            PAT_CONN:  dur = 12'd500;
            PAT_LOCAL: dur = (step == 3'd0) ? 12'd60 : 12'd2940;
            PAT_CLOUD:
            begin
                case (step)
                    3'd0, 3'd2: dur = 12'd60;
                    3'd1:       dur = 12'd160;
                    default:    dur = 12'd2720;
                endcase
            end
            PAT_FAULT: dur = (step == 3'd5) ? 12'd600 : 12'd80;
            PAT_OTA:   dur = 12'd50;
            default:   dur = 12'd0;
        endcase
        return dur;
    endfunction

    // every cyclic table lights on even steps and goes dark on odd ones
    function automatic logic step_lit(input logic [STEP_W-1:0] step);
        return ~step[0];
    endfunction

endpackage

// ===== hw/rtl/slbs_core.sv =====
// ---------------------------------------------------------------------------
// slbs_core
// pattern state registers and the per-item tick / set update
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slbs_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             command,
    input  logic [slbs_pkg::PAT_W-1:0]       new_pattern,
    input  logic [slbs_pkg::TIME_W-1:0]      now_ms,
    input  logic                             led_present,
    input  logic                             active_low,
    output slbs_pkg::slbs_result_t           result
);

    logic [slbs_pkg::PAT_W-1:0]  pattern_reg, pattern_next;
    logic [slbs_pkg::STEP_W-1:0] step_reg, step_next;
    logic [slbs_pkg::TIME_W-1:0] phase_reg, phase_next;
    logic                        lit_reg, lit_next;

    logic [slbs_pkg::STEP_W-1:0] count;
    logic [slbs_pkg::STEP_W-1:0] cur_step;
    logic [slbs_pkg::STEP_W-1:0] adv_step;
    logic [slbs_pkg::TIME_W-1:0] elapsed;
    logic                        expired;
    logic                        drove;

    always_comb
    begin
        count    = slbs_pkg::step_count(pattern_reg);
        cur_step = (step_reg < count) ? step_reg : '0;
        elapsed  = now_ms - phase_reg;
        expired  = elapsed >= slbs_pkg::TIME_W'(slbs_pkg::step_dur(pattern_reg, cur_step));
        adv_step = cur_step + 3'd1;
        if (adv_step >= count)
        begin
            adv_step = '0;
        end

        pattern_next = pattern_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        lit_next     = lit_reg;
        drove        = 1'b0;

        if (command == slbs_pkg::CMD_SET)
        begin
            if (new_pattern <= slbs_pkg::PAT_MAX && new_pattern != pattern_reg)
            begin
                pattern_next = new_pattern;
                step_next    = '0;
                phase_next   = now_ms;
                if (new_pattern == slbs_pkg::PAT_OFF)
                begin
                    lit_next = 1'b0;
                    drove    = 1'b1;
                end
                else if (new_pattern == slbs_pkg::PAT_SOLID ||
                         new_pattern == slbs_pkg::PAT_BOOT)
                begin
                    lit_next = 1'b1;
                    drove    = 1'b1;
                end
            end
        end
        else if (count != '0 && expired)
        begin
            step_next  = adv_step;
            phase_next = now_ms;
            lit_next   = slbs_pkg::step_lit(adv_step);
            drove      = 1'b1;
        end

        result.pin_level       = led_present & (lit_next ^ active_low);
        result.led_lit         = lit_next;
        result.pin_written     = led_present & drove;
        result.current_pattern = pattern_next;
        result.step_index      = step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= slbs_pkg::PAT_BOOT;
            step_reg    <= '0;
            phase_reg   <= '0;
            lit_reg     <= 1'b1;
        end
        else if (accept)
        begin
            pattern_reg <= pattern_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            lit_reg     <= lit_next;
        end
    end

    // static patterns never leave step zero
    `ASSERT_IMPLIES(a_static_step_zero, clk, rst_n,
        slbs_pkg::step_count(pattern_reg) == '0, step_reg == '0)
    // cyclic patterns keep the step inside their table
    `ASSERT_IMPLIES(a_cyclic_step_in_range, clk, rst_n,
        slbs_pkg::step_count(pattern_reg) != '0,
        step_reg < slbs_pkg::step_count(pattern_reg))

endmodule

// ===== hw/rtl/slbs_out_stage.sv =====
// ---------------------------------------------------------------------------
// slbs_out_stage
// result register with valid/ready toward the receiver
// ---------------------------------------------------------------------------
module slbs_out_stage
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  slbs_pkg::slbs_result_t d,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic                   can_load,
    output slbs_pkg::slbs_result_t q
);

    logic                   valid_reg, valid_next;
    slbs_pkg::slbs_result_t data_reg;

    // free when empty or being drained this cycle
    assign can_load = ~valid_reg | out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

    assign out_valid = valid_reg;
    assign q         = data_reg;

endmodule

// ===== hw/rtl/status_led_blink_sequencer_unit.sv =====
// ---------------------------------------------------------------------------
// status_led_blink_sequencer_unit
// status led pattern sequencer: set/tick items in, pin level results out
// ---------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carry one item (command, new_pattern,
//     now_ms); a set item selects a pattern, a tick item advances time
//   output channel: out_valid/out_ready carry one result per item
//     (pin_level, led_lit, pin_written, current_pattern, step_index)
//   config port: cfg_we writes cfg_wdata into register cfg_addr
//     (led_present, active_low); write only while no item is in flight
//   latency: the result of an item is valid one cycle after acceptance
//   throughput: one item per cycle; the blink state update and the
//     32-bit elapsed-time compare fit in the single cycle between the
//     input handshake and the result register
//   stall: while the receiver holds out_ready low the result register
//     stays full and in_ready drops; it rises again as the result drains
//   reset: pattern booting, step 0, phase start 0, led lit;
//     led_present = 1, active_low = 0, no result pending
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module status_led_blink_sequencer_unit
(
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration port
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic                        cfg_wdata,

    // input items
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [slbs_pkg::PAT_W-1:0]  new_pattern,
    input  logic [slbs_pkg::TIME_W-1:0] now_ms,

    // result items
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pin_level,
    output logic                        led_lit,
    output logic                        pin_written,
    output logic [slbs_pkg::PAT_W-1:0]  current_pattern,
    output logic [slbs_pkg::STEP_W-1:0] step_index
);

    logic                   led_present_reg;
    logic                   active_low_reg;
    logic                   accept;
    logic                   can_load;
    slbs_pkg::slbs_result_t core_result;
    slbs_pkg::slbs_result_t out_result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_present_reg <= 1'b1;
            active_low_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                slbs_pkg::REG_LED_PRESENT: led_present_reg <= cfg_wdata;
                slbs_pkg::REG_ACTIVE_LOW:  active_low_reg  <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    // an item enters whenever the result register can take its result
    assign in_ready = can_load;
    assign accept   = in_valid & can_load;

    // blink state and per-item update
    slbs_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .command     (command),
        .new_pattern (new_pattern),
        .now_ms      (now_ms),
        .led_present (led_present_reg),
        .active_low  (active_low_reg),
        .result      (core_result)
    );

    // result register toward the receiver
    slbs_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .d         (core_result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .q         (out_result)
    );

    assign pin_level       = out_result.pin_level;
    assign led_lit         = out_result.led_lit;
    assign pin_written     = out_result.pin_written;
    assign current_pattern = out_result.current_pattern;
    assign step_index      = out_result.step_index;

    // every accepted item shows up as a result in the next cycle
    `ASSERT_IMPLIES_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid)

endmodule

// ===== tb/led_tracker_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// led_tracker_pkg
// mirror of the blink sequencer state and an in-order check of its results
// ---------------------------------------------------------------------------
package led_tracker_pkg;

    import slbs_pkg::*;

    class led_pattern_tracker;

        logic              present;
        logic              low_active;
        logic [PAT_W-1:0]  pattern;
        logic [STEP_W-1:0] step;
        logic [TIME_W-1:0] phase_start;
        logic              lit;
        slbs_result_t      expected_leds[$];
        int                errors;

        function new();
            present     = 1'b1;
            low_active  = 1'b0;
            pattern     = PAT_BOOT;
            step        = '0;
            phase_start = '0;
            lit         = 1'b1;
            errors      = 0;
        endfunction

        function void set_regs(input logic led_present, input logic active_low);
            present    = led_present;
            low_active = active_low;
        endfunction

        // returns 1 for a set that changes the pattern or a tick on a cyclic pattern
        function bit note_item(input logic cmd, input logic [PAT_W-1:0] pat,
                               input logic [TIME_W-1:0] now);
            int unsigned       ms [6];
            logic [5:0]        lit_mask;
            int                n_steps;
            logic [STEP_W-1:0] s;
            logic [TIME_W-1:0] elapsed;
            bit                drove;
            bit                live;
            slbs_result_t      res;

            drove    = 1'b0;
            live     = 1'b0;
            n_steps  = 0;
            ms       = '{default: 0};
            lit_mask = '0;

            if (cmd == CMD_SET)
            begin
                if (pat <= PAT_MAX && pat != pattern)
                begin
                    live        = 1'b1;
                    pattern     = pat;
                    step        = '0;
                    phase_start = now;
                    if (pat == PAT_OFF)
                    begin
                        lit   = 1'b0;
                        drove = 1'b1;
                    end
                    else if (pat == PAT_SOLID || pat == PAT_BOOT)
                    begin
                        lit   = 1'b1;
                        drove = 1'b1;
                    end
                end
            end
            else
            begin
                // step durations in ms, lit mask bit i is the level of step i
                case (pattern)
                    PAT_PROV:
                    begin
                        n_steps  = 2;
                        ms       = '{120, 120, 0, 0, 0, 0};
                        lit_mask = 6'b000001;
                    end
                    PAT_CONN:
                    begin
                        n_steps  = 2;
                        ms       = '{500, 500, 0, 0, 0, 0};
                        lit_mask = 6'b000001;
                    end
                    PAT_LOCAL:
                    begin
                        n_steps  = 2;
                        ms       = '{60, 2940, 0, 0, 0, 0};
                        lit_mask = 6'b000001;
                    end
                    PAT_CLOUD:
                    begin
                        n_steps  = 4;
                        ms       = '{60, 160, 60, 2720, 0, 0};
                        lit_mask = 6'b000101;
                    end
                    PAT_FAULT:
                    begin
                        n_steps  = 6;
                        ms       = '{80, 80, 80, 80, 80, 600};
                        lit_mask = 6'b010101;
                    end
                    PAT_OTA:
                    begin
                        n_steps  = 2;
                        ms       = '{50, 50, 0, 0, 0, 0};
                        lit_mask = 6'b000001;
                    end
                    default: n_steps = 0;
                endcase

                if (n_steps != 0)
                begin
                    live    = 1'b1;
                    s       = (step < n_steps) ? step : '0;
                    elapsed = now - phase_start;
                    if (elapsed >= ms[s])
                    begin
                        if (s + 1 >= n_steps)
                            s = '0;
                        else
                            s = s + 3'd1;
                        step        = s;
                        phase_start = now;
                        lit         = lit_mask[s];
                        drove       = 1'b1;
                    end
                end
            end

            res.pin_level       = present ? (lit ^ low_active) : 1'b0;
            res.led_lit         = lit;
            res.pin_written     = drove && present;
            res.current_pattern = pattern;
            res.step_index      = step;
            expected_leds.push_back(res);
            return live;
        endfunction

        function void check_result(input slbs_result_t got);
            slbs_result_t want;

            if (expected_leds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing expected: %h", got);
                return;
            end
            want = expected_leds.pop_front();
            if (got.pin_level !== want.pin_level || got.led_lit !== want.led_lit ||
                got.pin_written !== want.pin_written ||
                got.current_pattern !== want.current_pattern ||
                got.step_index !== want.step_index)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch (exp/act): pin_level %b/%b led_lit %b/%b ",
                              "pin_written %b/%b pattern %0d/%0d step %0d/%0d"},
                             want.pin_level, got.pin_level, want.led_lit, got.led_lit,
                             want.pin_written, got.pin_written,
                             want.current_pattern, got.current_pattern,
                             want.step_index, got.step_index);
            end
        endfunction

    endclass

endpackage

// ===== tb/tb_status_led_blink_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_status_led_blink_sequencer_unit
// directed then random set/tick items under every led_present/active_low
// combination, random idling on both channels and one long output stall;
// every result is checked in order against a tracker of the blink state
// ---------------------------------------------------------------------------
module tb_status_led_blink_sequencer_unit;

    import slbs_pkg::*;
    import led_tracker_pkg::*;

    // live items per random phase, length of the long output stall
    localparam int     PHASE_ITEMS  = 190;
    localparam int     PHASE_COUNT  = 5;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 4;
    localparam longint TIMEOUT_NS   = 5_000_000;

    // register settings per random phase, bit i belongs to phase i
    localparam logic [PHASE_COUNT-1:0] PHASE_PRESENT = 5'b10011;
    localparam logic [PHASE_COUNT-1:0] PHASE_LOW     = 5'b01010;

    // codes beyond the last pattern, ignored by a set
    localparam logic [PAT_W-1:0] PAT_BAD_LO = 4'd9;
    localparam logic [PAT_W-1:0] PAT_BAD_HI = 4'd15;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_addr;
    logic                cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    logic                command;
    logic [PAT_W-1:0]    new_pattern;
    logic [TIME_W-1:0]   now_ms;
    logic                out_valid;
    logic                out_ready;
    logic                pin_level;
    logic                led_lit;
    logic                pin_written;
    logic [PAT_W-1:0]    current_pattern;
    logic [STEP_W-1:0]   step_index;

    led_pattern_tracker  tracker;

    // long output stall: requested by the stimulus, timed by its own process
    logic                hold_req;
    logic                hold_active;

    // remaining items of a no-idle stretch on each side
    int                  in_run_left  = 0;
    int                  out_run_left = 0;

    // live items of the current phase
    int                  live_count;

    status_led_blink_sequencer_unit i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .new_pattern     (new_pattern),
        .now_ms          (now_ms),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pin_level       (pin_level),
        .led_lit         (led_lit),
        .pin_written     (pin_written),
        .current_pattern (current_pattern),
        .step_index      (step_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // random idle gap before the next item, with occasional no-idle stretches
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            run_left = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    // offer one item after a random gap, return at the edge that takes it
    task automatic send_item(input logic cmd, input logic [PAT_W-1:0] pat,
                             input logic [TIME_W-1:0] now);
        int gap;

        gap = draw_wait(in_run_left);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // valid stays high straight into the next item when there is no gap
        in_valid    <= 1'b1;
        command     <= cmd;
        new_pattern <= pat;
        now_ms      <= now;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (tracker.note_item(cmd, pat, now))
            live_count++;
    endtask

    // accept one result after a random stall, or after the long hold-off
    task automatic take_result();
        int           stall;
        slbs_result_t got;

        stall = draw_wait(out_run_left);
        if (stall > 0 || hold_active)
        begin
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
            while (hold_active) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
        got.pin_level       = pin_level;
        got.led_lit         = led_lit;
        got.pin_written     = pin_written;
        got.current_pattern = current_pattern;
        got.step_index      = step_index;
        tracker.check_result(got);
    endtask

    // both registers, back to back, block idle
    task automatic write_config(input logic present, input logic low);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LED_PRESENT;
        cfg_wdata <= present;
        @(posedge clk);
        cfg_addr  <= REG_ACTIVE_LOW;
        cfg_wdata <= low;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tracker.set_regs(present, low);
    endtask

    // stop offering, let every expected result drain, then idle on as a margin
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.expected_leds.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // the receiver runs on its own for the whole test
    initial
    begin : result_sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever take_result();
    end

    // holds the output off once requested, then releases it
    initial
    begin : pressure_ctl
        hold_active = 1'b0;
        do @(posedge clk); while (!hold_req);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int                r;
        int                phase;
        logic [PAT_W-1:0]  pat;
        logic [TIME_W-1:0] clock_ms;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = REG_LED_PRESENT;
        cfg_wdata   = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_TICK;
        new_pattern = PAT_BOOT;
        now_ms      = '0;
        hold_req    = 1'b0;
        live_count  = 0;
        tracker     = new();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset register values: booting, led lit
        send_item(CMD_TICK, PAT_FAULT,  32'd0);          // tick on a static pattern
        send_item(CMD_SET,  PAT_BOOT,   32'd5);          // same pattern, ignored
        send_item(CMD_SET,  PAT_BAD_LO, 32'd7);          // unknown codes, ignored
        send_item(CMD_SET,  PAT_BAD_HI, 32'hFFFF_FFFF);
        send_item(CMD_SET,  PAT_SOLID,  32'd100);        // static sets write the pin
        send_item(CMD_SET,  PAT_OFF,    32'd110);
        send_item(CMD_TICK, PAT_BAD_HI, 32'd5000);       // off ignores time
        send_item(CMD_SET,  PAT_PROV,   32'd1000);       // cyclic set, no pin write
        send_item(CMD_TICK, PAT_BOOT,   32'd1119);       // one ms short of expiry
        send_item(CMD_TICK, PAT_BOOT,   32'd1120);       // expires exactly
        send_item(CMD_TICK, PAT_OTA,    32'd1240);       // back to step 0
        send_item(CMD_SET,  PAT_CONN,   32'd2000);
        send_item(CMD_TICK, PAT_SOLID,  32'd2500);
        send_item(CMD_SET,  PAT_LOCAL,  32'd3000);
        send_item(CMD_TICK, PAT_BOOT,   32'd3060);
        send_item(CMD_TICK, PAT_BOOT,   32'd6000);       // long dark step
        send_item(CMD_SET,  PAT_CLOUD,  32'd7000);
        send_item(CMD_TICK, PAT_BOOT,   32'd7060);
        send_item(CMD_TICK, PAT_BOOT,   32'd7220);
        send_item(CMD_TICK, PAT_BOOT,   32'd7280);
        send_item(CMD_SET,  PAT_FAULT,  32'd8000);
        send_item(CMD_TICK, PAT_BOOT,   32'd8080);
        send_item(CMD_SET,  PAT_OTA,    32'hFFFF_FFE0);  // phase starts just before wrap
        send_item(CMD_TICK, PAT_BOOT,   32'h0000_0012);  // elapsed measured across wrap
        send_item(CMD_TICK, PAT_BOOT,   32'hFFFF_FFFF);  // largest time value
        send_item(CMD_SET,  PAT_BOOT,   32'd0);          // booting writes the pin lit

        // random phases: mostly cyclic patterns ticked forward in small steps,
        // with noise sets, big time jumps and a few unknown codes
        clock_ms = 32'd10000;
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            write_config(PHASE_PRESENT[phase], PHASE_LOW[phase]);
            live_count = 0;
            while (live_count < PHASE_ITEMS)
            begin
                // long output stall midway through the second phase
                if (phase == 1 && live_count >= 60)
                    hold_req <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 7)
                begin
                    pat = PAT_W'($urandom_range(PAT_PROV, PAT_OTA));
                    send_item(CMD_SET, pat, clock_ms);
                end
                else if (r < 12)
                begin
                    pat = PAT_W'($urandom());
                    send_item(CMD_SET, pat, clock_ms);
                end
                else if (r < 14)
                begin
                    // jump anywhere, wrap included
                    clock_ms = $urandom();
                    pat      = PAT_W'($urandom());
                    send_item(CMD_TICK, pat, clock_ms);
                end
                else
                begin
                    if ($urandom_range(0, 4) == 0)
                        clock_ms = clock_ms + $urandom_range(0, 3000);
                    else
                        clock_ms = clock_ms + $urandom_range(0, 130);
                    pat = PAT_W'($urandom());
                    send_item(CMD_TICK, pat, clock_ms);
                end
            end
        end

        wait_idle();
        if (tracker.errors == 0 && tracker.expected_leds.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
